>>> sv/ucp_pkg.sv
// ----------------------------------------------------------------------------
// ucp_pkg
// Shared types and constants of the URL component parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ucp_pkg;

  localparam int CHAR_W   = 8;
  localparam int PART_W   = 2;
  localparam int STATUS_W = 4;
  localparam int PORT_W   = 16;
  localparam int PVAL_W   = 17;
  localparam int SCAP_W   = 5;
  localparam int HCAP_W   = 13;
  localparam int PCNT_W   = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCHEME_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_CAP   = 2'd2;

  localparam logic [SCAP_W-1:0] SCHEME_CAP_RST = 5'd6;
  localparam logic [HCAP_W-1:0] HOST_CAP_RST   = 13'd512;
  localparam logic [HCAP_W-1:0] PATH_CAP_RST   = 13'd512;

  // component tags
  localparam logic [PART_W-1:0] PART_SCHEME = 2'd0;
  localparam logic [PART_W-1:0] PART_HOST   = 2'd1;
  localparam logic [PART_W-1:0] PART_PATH   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY         = 4'd0,
    ST_OK           = 4'd1,
    ST_SCHEME_LONG  = 4'd2,
    ST_SCHEME_UNSUP = 4'd3,
    ST_NO_SEP       = 4'd4,
    ST_HOST_LONG    = 4'd5,
    ST_HOST_MISSING = 4'd6,
    ST_PORT_LONG    = 4'd7,
    ST_PORT_DIGIT   = 4'd8,
    ST_PORT_RANGE   = 4'd9
  } status_e;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;

  localparam logic [39:0] SCHEME_HTTP  = 40'h00_6874_7470;
  localparam logic [39:0] SCHEME_HTTPS = 40'h68_7474_7073;

  localparam logic [PVAL_W-1:0] PORT_HTTP  = 17'd80;
  localparam logic [PVAL_W-1:0] PORT_HTTPS = 17'd443;

  // usable characters per part, already reduced by one
  typedef struct packed {
    logic [SCAP_W-1:0] scheme;
    logic [HCAP_W-1:0] host;
    logic [HCAP_W-1:0] path;
  } ucp_limits_t;

  function automatic logic [SCAP_W-1:0] scheme_limit(input logic [SCAP_W-1:0] cap);
    scheme_limit = (cap == '0) ? '0 : cap - 5'd1;
  endfunction

  function automatic logic [HCAP_W-1:0] part_limit(input logic [HCAP_W-1:0] cap);
    part_limit = (cap == '0) ? '0 : cap - 13'd1;
  endfunction

endpackage

`default_nettype wire

>>> sv/ucp_if.sv
// ----------------------------------------------------------------------------
// ucp_if
// Valid/ready channels of the URL component parser: input bytes and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucp_in_if;
  import ucp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] url_byte;
  logic              final_byte;

  modport source (output valid, output url_byte, output final_byte, input ready);
  modport sink   (input valid, input url_byte, input final_byte, output ready);
endinterface

interface ucp_out_if;
  import ucp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   out_char;
  logic                char_valid;
  logic [PART_W-1:0]   part;
  logic [STATUS_W-1:0] status;
  logic [PORT_W-1:0]   port_number;
  logic                secure;

  modport source (output valid, output out_char, output char_valid, output part,
                  output status, output port_number, output secure, input ready);
  modport sink   (input valid, input out_char, input char_valid, input part,
                  input status, input port_number, input secure, output ready);
endinterface

`default_nettype wire

>>> sv/ucp_cfg.sv
// ----------------------------------------------------------------------------
// ucp_cfg
// Capacity registers; keeps each capacity as its usable character limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ucp_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ucp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ucp_pkg::CFG_W-1:0]         cfg_data_i,
  output ucp_pkg::ucp_limits_t              limits_o
);
  import ucp_pkg::*;

  ucp_limits_t lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.scheme <= scheme_limit(SCHEME_CAP_RST);
      lim_q.host   <= part_limit(HOST_CAP_RST);
      lim_q.path   <= part_limit(PATH_CAP_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCHEME_CAP: lim_q.scheme <= scheme_limit(cfg_data_i[SCAP_W-1:0]);
        CFG_HOST_CAP:   lim_q.host   <= part_limit(cfg_data_i[HCAP_W-1:0]);
        CFG_PATH_CAP:   lim_q.path   <= part_limit(cfg_data_i[HCAP_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign limits_o = lim_q;

endmodule

`default_nettype wire

>>> sv/url_component_parser_core.sv
// ----------------------------------------------------------------------------
// url_component_parser_core
// Splits an http/https URL, one byte per item, into tagged scheme, host and
// path characters and reports a status code, port and secure flag.
// ----------------------------------------------------------------------------
// The parser takes one URL byte per clock cycle unless a waiting result holds
// the input; each byte gives exactly one result in the cycle after, from the output
// register. A new byte is taken whenever that register is empty or its result
// leaves in the same cycle, so a result that waits to be taken holds the input.
// All per-byte decisions (phase compares, the times-ten port add and the
// end-of-URL check) sit between the parse state and that output register.
// The user must write capacity registers only while no item is in flight; the
// block itself does not enforce this. A write takes effect on the next byte.
`default_nettype none

module url_component_parser_core #(
  parameter int MAX_URL_BYTES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ucp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ucp_pkg::CFG_W-1:0]     cfg_data_i,
  ucp_in_if.sink                        in_i,
  ucp_out_if.source                     out_o
);
  import ucp_pkg::*;

  localparam int UCNT_W = $clog2(MAX_URL_BYTES);
  localparam logic [UCNT_W-1:0] UCNT_MAX = UCNT_W'(MAX_URL_BYTES - 1);

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_SEP,
    PH_HOST,
    PH_PORT,
    PH_PATH,
    PH_HOLD
  } phase_e;

  ucp_limits_t lim;

  ucp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .limits_o   (lim)
  );

  phase_e            phase_q, phase_d;
  logic [PCNT_W-1:0] cnt_q, cnt_d;
  logic [39:0]       sch_q, sch_d;
  logic [1:0]        sep_q, sep_d;
  logic [PVAL_W-1:0] pval_q, pval_d;
  logic [2:0]        pdig_q, pdig_d;
  status_e           err_q, err_d;
  logic [UCNT_W-1:0] ucnt_q, ucnt_d;
  logic              sec_q, sec_d;

  logic              emit_v;
  logic [CHAR_W-1:0] emit_c;
  logic [PART_W-1:0] emit_p;
  logic              present;
  logic              do_eos;
  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] lc;
  status_e           status;
  logic              accept;

  logic                out_vld_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                char_vld_q;
  logic [PART_W-1:0]   part_q;
  status_e             status_q;
  logic [PORT_W-1:0]   port_q;
  logic                secure_q;

  assign c       = in_i.url_byte;
  assign lc      = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | 8'h20) : c;
  assign present = ucnt_q < UCNT_MAX;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    sch_d   = sch_q;
    sep_d   = sep_q;
    pval_d  = pval_q;
    pdig_d  = pdig_q;
    err_d   = err_q;
    sec_d   = sec_q;
    ucnt_d  = present ? ucnt_q + 1'b1 : ucnt_q;
    emit_v  = 1'b0;
    emit_c  = '0;
    emit_p  = PART_SCHEME;

    if (present && phase_q != PH_HOLD && c != CH_NUL) begin
      unique case (phase_q)
        PH_SCHEME: begin
          if (c == CH_COLON) begin
            if (cnt_q == 13'd4 && sch_q == SCHEME_HTTP) begin
              sec_d   = 1'b0;
              phase_d = PH_SEP;
              sep_d   = 2'd1;
            end else if (cnt_q == 13'd5 && sch_q == SCHEME_HTTPS) begin
              sec_d   = 1'b1;
              phase_d = PH_SEP;
              sep_d   = 2'd1;
            end else begin
              phase_d = PH_HOLD;
              err_d   = ST_SCHEME_UNSUP;
            end
          end else if (cnt_q >= PCNT_W'(lim.scheme)) begin
            phase_d = PH_HOLD;
            err_d   = ST_SCHEME_LONG;
          end else begin
            cnt_d  = cnt_q + 1'b1;
            sch_d  = {sch_q[31:0], lc};
            emit_v = 1'b1;
            emit_c = lc;
            emit_p = PART_SCHEME;
          end
        end
        PH_SEP: begin
          if (c != CH_SLASH) begin
            phase_d = PH_HOLD;
            err_d   = ST_NO_SEP;
          end else if (sep_q >= 2'd2) begin
            phase_d = PH_HOST;
            cnt_d   = '0;
            sep_d   = '0;
          end else begin
            sep_d = sep_q + 1'b1;
          end
        end
        PH_HOST: begin
          if (c == CH_COLON || c == CH_SLASH) begin
            if (cnt_q == '0) begin
              phase_d = PH_HOLD;
              err_d   = ST_HOST_MISSING;
            end else if (c == CH_COLON) begin
              phase_d = PH_PORT;
              pval_d  = '0;
              pdig_d  = '0;
            end else begin
              phase_d = PH_PATH;
              pval_d  = sec_q ? PORT_HTTPS : PORT_HTTP;
              cnt_d   = '0;
              if (lim.path != '0) begin
                cnt_d  = 13'd1;
                emit_v = 1'b1;
                emit_c = c;
                emit_p = PART_PATH;
              end
            end
          end else if (cnt_q >= lim.host) begin
            phase_d = PH_HOLD;
            err_d   = ST_HOST_LONG;
          end else begin
            cnt_d  = cnt_q + 1'b1;
            emit_v = 1'b1;
            emit_c = lc;
            emit_p = PART_HOST;
          end
        end
        PH_PORT: begin
          if (c == CH_SLASH) begin
            if (pval_q == '0 || pval_q[PVAL_W-1]) begin
              phase_d = PH_HOLD;
              err_d   = ST_PORT_RANGE;
            end else begin
              phase_d = PH_PATH;
              cnt_d   = '0;
              if (lim.path != '0) begin
                cnt_d  = 13'd1;
                emit_v = 1'b1;
                emit_c = c;
                emit_p = PART_PATH;
              end
            end
          end else if (pdig_q >= 3'd5) begin
            phase_d = PH_HOLD;
            err_d   = ST_PORT_LONG;
          end else if (c < CH_ZERO || c > CH_NINE) begin
            phase_d = PH_HOLD;
            err_d   = ST_PORT_DIGIT;
          end else begin
            pdig_d = pdig_q + 1'b1;
            pval_d = (pval_q << 3) + (pval_q << 1) + PVAL_W'(c - CH_ZERO);
          end
        end
        PH_PATH: begin
          if (cnt_q < lim.path) begin
            cnt_d  = cnt_q + 1'b1;
            emit_v = 1'b1;
            emit_c = c;
            emit_p = PART_PATH;
          end
        end
        default: begin
        end
      endcase
    end

    // end of URL: zero byte or final flag
    do_eos = ((present && phase_q != PH_HOLD && c == CH_NUL) || in_i.final_byte)
             && phase_d != PH_HOLD;
    if (do_eos) begin
      unique case (phase_d)
        PH_SCHEME: begin
          if (cnt_d == 13'd4 && sch_d == SCHEME_HTTP) begin
            sec_d = 1'b0;
            err_d = ST_NO_SEP;
          end else if (cnt_d == 13'd5 && sch_d == SCHEME_HTTPS) begin
            sec_d = 1'b1;
            err_d = ST_NO_SEP;
          end else begin
            err_d = ST_SCHEME_UNSUP;
          end
        end
        PH_SEP: err_d = ST_NO_SEP;
        PH_HOST: begin
          if (cnt_d == '0) begin
            err_d = ST_HOST_MISSING;
          end else begin
            pval_d = sec_d ? PORT_HTTPS : PORT_HTTP;
            err_d  = ST_OK;
          end
        end
        PH_PORT: err_d = (pval_d == '0 || pval_d[PVAL_W-1]) ? ST_PORT_RANGE : ST_OK;
        PH_PATH: err_d = ST_OK;
        default: begin
        end
      endcase
      phase_d = PH_HOLD;
    end

    status = (phase_d == PH_HOLD) ? err_d : ST_BUSY;
  end

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SCHEME;
      cnt_q     <= '0;
      sch_q     <= '0;
      sep_q     <= '0;
      pval_q    <= '0;
      pdig_q    <= '0;
      err_q     <= ST_BUSY;
      ucnt_q    <= '0;
      sec_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        out_vld_q <= 1'b1;
        if (in_i.final_byte) begin
          phase_q <= PH_SCHEME;
          cnt_q   <= '0;
          sch_q   <= '0;
          sep_q   <= '0;
          pval_q  <= '0;
          pdig_q  <= '0;
          err_q   <= ST_BUSY;
          ucnt_q  <= '0;
          sec_q   <= 1'b0;
        end else begin
          phase_q <= phase_d;
          cnt_q   <= cnt_d;
          sch_q   <= sch_d;
          sep_q   <= sep_d;
          pval_q  <= pval_d;
          pdig_q  <= pdig_d;
          err_q   <= err_d;
          ucnt_q  <= ucnt_d;
          sec_q   <= sec_d;
        end
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_char_q <= emit_c;
      char_vld_q <= emit_v;
      part_q     <= emit_p;
      status_q   <= status;
      port_q     <= (status == ST_OK) ? pval_d[PORT_W-1:0] : '0;
      secure_q   <= (status == ST_OK) && sec_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_char    = out_char_q;
  assign out_o.char_valid  = char_vld_q;
  assign out_o.part        = part_q;
  assign out_o.status      = status_q;
  assign out_o.port_number = port_q;
  assign out_o.secure      = secure_q;

`ifndef SYNTH
  a_final_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.final_byte |=> phase_q == PH_SCHEME && ucnt_q == '0)
    else $error("parser did not restart after final byte");

  a_hold_has_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HOLD |-> err_q != ST_BUSY)
    else $error("hold phase without result code");

  a_ok_has_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q == ST_OK |-> port_q != '0)
    else $error("done status with zero port");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucnt_q <= UCNT_MAX)
    else $error("URL byte count beyond limit");
`endif

endmodule

`default_nettype wire
